FILE: src/erv_pkg.sv
// Package for the Euler-angle vector rotation block.
// Holds shared types, fixed-point constants, the CORDIC arctangent table and
// the matrix build sequence table. No dependencies.
package erv_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROLL  = 2'd0,
    REG_PITCH = 2'd1,
    REG_YAW   = 2'd2
  } cfg_reg_e;

  // Matrix builder sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROT,
    ST_MUL,
    ST_FIN
  } dcm_state_e;

  // Operand sources for the matrix build multiplies.
  typedef enum logic [2:0] {
    SRC_SPHI,
    SRC_CPHI,
    SRC_STH,
    SRC_CTH,
    SRC_SPSI,
    SRC_CPSI,
    SRC_CPS,
    SRC_SPS
  } src_e;

  localparam int ATAN_ENTRIES = 24;
  localparam int CW           = 34;   // CORDIC datapath width
  localparam int TW           = 33;   // Q2.30 trig and product width
  localparam int NUM_MULS     = 14;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [16:0]   HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0]   PI_Q13      = 17'sd25736;

  // Stored direction cosine matrix, row major, Q1.15 entries.
  typedef logic [8:0][15:0] mat_t;

  // Status from the matrix builder to the rest of the block.
  typedef struct packed {
    logic busy;
    mat_t mat;
  } dcm_status_t;

  // Arctangent of 2^-i in Q2.30, truncated.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // First operand of each build multiply.
  function automatic src_e step_src_a(input logic [3:0] k);
    src_e r;
    unique case (k)
      4'd0:  r = SRC_CPSI;
      4'd1:  r = SRC_SPSI;
      4'd2:  r = SRC_CPSI;
      4'd3:  r = SRC_SPSI;
      4'd4:  r = SRC_CPS;
      4'd5:  r = SRC_SPSI;
      4'd6:  r = SRC_SPS;
      4'd7:  r = SRC_CPSI;
      4'd8:  r = SRC_CTH;
      4'd9:  r = SRC_CPS;
      4'd10: r = SRC_SPSI;
      4'd11: r = SRC_SPS;
      4'd12: r = SRC_CPSI;
      4'd13: r = SRC_CTH;
      default: r = SRC_CTH;
    endcase
    return r;
  endfunction

  // Second operand of each build multiply.
  function automatic src_e step_src_b(input logic [3:0] k);
    src_e r;
    unique case (k)
      4'd0:  r = SRC_STH;
      4'd1:  r = SRC_STH;
      4'd2:  r = SRC_CTH;
      4'd3:  r = SRC_CTH;
      4'd4:  r = SRC_SPHI;
      4'd5:  r = SRC_CPHI;
      4'd6:  r = SRC_SPHI;
      4'd7:  r = SRC_CPHI;
      4'd8:  r = SRC_SPHI;
      4'd9:  r = SRC_CPHI;
      4'd10: r = SRC_SPHI;
      4'd11: r = SRC_CPHI;
      4'd12: r = SRC_SPHI;
      4'd13: r = SRC_CPHI;
      default: r = SRC_CPHI;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.15 with round to nearest and saturation.
  function automatic logic [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic [15:0] r;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      r = 16'h7FFF;
    end else if (t < -34'sd32768) begin
      r = 16'h8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

FILE: src/erv_dcm.sv
// Direction cosine matrix builder: a shared iterative CORDIC for the three
// angles, a sequenced multiplier for the products, and the matrix registers.
// Depends on erv_pkg.
module erv_dcm import erv_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output dcm_status_t status_o
);

  localparam int NSTEP  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int ITER_W = $clog2(NSTEP);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NSTEP - 1);
  localparam logic [3:0] MUL_DONE = 4'(NUM_MULS);

  dcm_state_e state_q, state_d;

  logic signed [15:0]   angle_q [3];
  logic [1:0]           ang_q;
  logic [ITER_W-1:0]    iter_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic                 neg_q;
  logic signed [TW-1:0] sin_q [3];
  logic signed [TW-1:0] cos_q [3];
  logic [3:0]           k_q, pk_q;
  logic                 pv_q;
  logic signed [2*TW-1:0] p_q;
  logic signed [TW-1:0] prod_q [NUM_MULS];
  mat_t                 mat_q;

  logic cfg_hit;
  logic busy;
  logic iter_done;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_ROLL || cfg_idx_i == REG_PITCH ||
                                cfg_idx_i == REG_YAW);
  assign iter_done = (iter_q == ITER_LAST);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cfg_hit) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_ROT;
      ST_ROT: begin
        if (iter_done) state_d = (ang_q == REG_YAW) ? ST_MUL : ST_LOAD;
      end
      ST_MUL: if (k_q == MUL_DONE) state_d = ST_FIN;
      ST_FIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Angle registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q[0] <= '0;
      angle_q[1] <= '0;
      angle_q[2] <= '0;
    end else if (cfg_hit) begin
      angle_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Quadrant fold of the current angle.
  logic signed [16:0] a_ext, a_adj;
  logic               a_neg;
  always_comb begin
    a_ext = 17'(angle_q[ang_q]);
    a_adj = a_ext;
    a_neg = 1'b0;
    if (a_ext > HALF_PI_Q13) begin
      a_adj = a_ext - PI_Q13;
      a_neg = 1'b1;
    end else if (a_ext < -HALF_PI_Q13) begin
      a_adj = a_ext + PI_Q13;
      a_neg = 1'b1;
    end
  end

  // One CORDIC rotation step.
  logic signed [CW-1:0] xs, ys, atan_v, x_n, y_n, z_n;
  always_comb begin
    xs     = x_q >>> iter_q;
    ys     = y_q >>> iter_q;
    atan_v = CW'(atan_q30(5'(iter_q)));
    if (!z_q[CW-1]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - atan_v;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + atan_v;
    end
  end

  // CORDIC registers and angle and iteration counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      iter_q <= '0;
    end else begin
      if (state_q == ST_IDLE) begin
        ang_q <= '0;
      end else if (state_q == ST_LOAD) begin
        iter_q <= '0;
      end else if (state_q == ST_ROT) begin
        iter_q <= iter_q + 1'b1;
        if (iter_done) ang_q <= ang_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      x_q   <= CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= CW'(a_adj) <<< 17;
      neg_q <= a_neg;
    end else if (state_q == ST_ROT) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (iter_done) begin
        sin_q[ang_q] <= neg_q ? TW'(-y_n) : TW'(y_n);
        cos_q[ang_q] <= neg_q ? TW'(-x_n) : TW'(x_n);
      end
    end
  end

  // Multiply operand selection.
  function automatic logic signed [TW-1:0] pick(input src_e s,
      input logic signed [TW-1:0] sp, input logic signed [TW-1:0] cp,
      input logic signed [TW-1:0] st, input logic signed [TW-1:0] ct,
      input logic signed [TW-1:0] ss, input logic signed [TW-1:0] cs,
      input logic signed [TW-1:0] cps, input logic signed [TW-1:0] sps);
    logic signed [TW-1:0] r;
    unique case (s)
      SRC_SPHI: r = sp;
      SRC_CPHI: r = cp;
      SRC_STH:  r = st;
      SRC_CTH:  r = ct;
      SRC_SPSI: r = ss;
      SRC_CPSI: r = cs;
      SRC_CPS:  r = cps;
      SRC_SPS:  r = sps;
      default:  r = sp;
    endcase
    return r;
  endfunction

  logic signed [TW-1:0] op_a, op_b;
  always_comb begin
    op_a = pick(step_src_a(k_q), sin_q[0], cos_q[0], sin_q[1], cos_q[1],
                sin_q[2], cos_q[2], prod_q[0], prod_q[1]);
    op_b = pick(step_src_b(k_q), sin_q[0], cos_q[0], sin_q[1], cos_q[1],
                sin_q[2], cos_q[2], prod_q[0], prod_q[1]);
  end

  // Multiply issue, then round back to Q2.30 in the following cycle.
  logic signed [2*TW-1:0] p_rnd;
  assign p_rnd = (p_q + (2*TW)'(64'sd536870912)) >>> 30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      pv_q <= 1'b0;
    end else begin
      pv_q <= (state_q == ST_MUL) && (k_q != MUL_DONE);
      if (state_q == ST_MUL) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= op_a * op_b;
    pk_q <= k_q;
    if (pv_q) prod_q[pk_q] <= p_rnd[TW-1:0];
  end

  // Final sums, rounding and saturation into the matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q    <= '0;
      mat_q[0] <= 16'h7FFF;
      mat_q[4] <= 16'h7FFF;
      mat_q[8] <= 16'h7FFF;
    end else if (state_q == ST_FIN) begin
      mat_q[0] <= to_q15(CW'(prod_q[2]));
      mat_q[1] <= to_q15(CW'(prod_q[3]));
      mat_q[2] <= to_q15(-CW'(sin_q[1]));
      mat_q[3] <= to_q15(CW'(prod_q[4]) - CW'(prod_q[5]));
      mat_q[4] <= to_q15(CW'(prod_q[6]) + CW'(prod_q[7]));
      mat_q[5] <= to_q15(CW'(prod_q[8]));
      mat_q[6] <= to_q15(CW'(prod_q[9]) + CW'(prod_q[10]));
      mat_q[7] <= to_q15(CW'(prod_q[11]) - CW'(prod_q[12]));
      mat_q[8] <= to_q15(CW'(prod_q[13]));
    end
  end

  assign status_o.busy = busy;
  assign status_o.mat  = mat_q;

endmodule

FILE: src/erv_mvm.sv
// Three-stage pipelined matrix-vector multiply with per-stage valid bits.
// Stage one selects the matrix or its transpose, two multiplies, three sums.
// Depends on erv_pkg.
module erv_mvm import erv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mat_t        mat_i,
  input  logic        hold_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [23:0] vec_x_i,
  input  logic [23:0] vec_y_i,
  input  logic [23:0] vec_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [25:0] rot_x_o,
  output logic [25:0] rot_y_o,
  output logic [25:0] rot_z_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  logic signed [15:0] coef_q [9];
  logic signed [23:0] vec_q  [3];
  logic signed [39:0] prod_q [9];
  logic [25:0]        rot_q  [3];

  // Each stage moves when its own slot is free or is being emptied.
  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1 && !hold_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i && !hold_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Coefficient selection, transposed when the action asks for it.
  logic signed [15:0] coef_d [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef_d[r*3+c] = action_i ? mat_i[c*3+r] : mat_i[r*3+c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      coef_q <= coef_d;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
    end
  end

  // Nine independent products.
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r*3+c] <= 40'(coef_q[r*3+c]) * 40'(vec_q[c]);
        end
      end
    end
  end

  // Row sums, rounded to nearest integer.
  logic signed [41:0] sum [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = (42'(prod_q[r*3]) + 42'(prod_q[r*3+1]) + 42'(prod_q[r*3+2])
                + 42'sd16384) >>> 15;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      for (int r = 0; r < 3; r++) begin
        rot_q[r] <= sum[r][25:0];
      end
    end
  end

  assign out_valid_o = v3_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];

endmodule

FILE: src/euler_rotation_vector_transform_unit.sv
// Top level of the Euler-angle vector rotation block.
// Instantiates erv_dcm (matrix builder) and erv_mvm (vector pipeline); uses erv_pkg.
//
// The block rotates signed 24-bit 3-vectors by a yaw-pitch-roll direction
// cosine matrix, or by its transpose when tuser is set, and takes one item
// per clock while no rebuild runs and the result side is not stalled; each
// item passes the select, multiply and sum stages of the three-stage multiply
// pipeline. Writing roll, pitch or yaw while no rebuild runs starts a rebuild
// of the matrix: one shared CORDIC runs the three angles in turn, then a single
// multiplier forms fourteen products. s_axis_tready stays low while the
// rebuild runs.
module euler_rotation_vector_transform_unit import erv_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // vec_x [23:0], vec_y [47:24], vec_z [71:48]
  input  logic [0:0]  s_axis_tuser,   // action [0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // rot_x [25:0], rot_y [51:26], rot_z [77:52], zero
);

  dcm_status_t status;
  logic [25:0] rot_x, rot_y, rot_z;

  erv_dcm #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dcm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .status_o  (status)
  );

  erv_mvm u_mvm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mat_i      (status.mat),
    .hold_i     (status.busy),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser[0]),
    .vec_x_i    (s_axis_tdata[23:0]),
    .vec_y_i    (s_axis_tdata[47:24]),
    .vec_z_i    (s_axis_tdata[71:48]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .rot_x_o    (rot_x),
    .rot_y_o    (rot_y),
    .rot_z_o    (rot_z)
  );

  assign m_axis_tdata = {2'b00, rot_z, rot_y, rot_x};

  // No item is taken while the matrix is being rebuilt.
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !s_axis_tready)
    else $error("input accepted during matrix rebuild");

  // A rebuild only starts from a configuration write.
  a_rebuild_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.busy) |-> $past(cfg_we_i))
    else $error("matrix rebuild without a configuration write");

  // A write to a defined register while no rebuild runs starts a rebuild in the next cycle.
  a_write_starts_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && !status.busy && (cfg_idx_i == REG_ROLL || cfg_idx_i == REG_PITCH ||
     cfg_idx_i == REG_YAW)) |=> status.busy)
    else $error("configuration write did not start a rebuild");

endmodule

FILE: sim/erv_rotation_checker.sv
`timescale 1ns / 100ps
// Checker for the Euler-angle vector rotation block: mirrors the configuration
// writes, predicts each rotated vector and compares it with the result stream.
// Depends on erv_pkg for the register index names.
module erv_rotation_checker import erv_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic [25:0] rot_z;
    logic [25:0] rot_y;
    logic [25:0] rot_x;
  } rot_vec_t;

  longint angle_q13 [3];
  longint dcm [9];
  rot_vec_t rot_expected_q[$];

  localparam longint ATAN_TAB [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  assign pending_count = rot_expected_q.size();

  // Rotation-mode CORDIC with quadrant folding, Q2.30 outputs.
  task automatic trig_of(input longint ang, output longint sn, output longint cs);
    longint x, y, z, t;
    bit fold;
    x = 652032874;
    y = 0;
    fold = 0;
    if (ang > 12868) begin
      ang -= 25736;
      fold = 1;
    end else if (ang < -12868) begin
      ang += 25736;
      fold = 1;
    end
    z = ang * 131072;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = t;
    end
    sn = fold ? -y : y;
    cs = fold ? -x : x;
  endtask

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint q15_sat(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic rebuild_dcm();
    longint sphi, cphi, sth, cth, spsi, cpsi, cps, sps;
    trig_of(angle_q13[REG_ROLL], sphi, cphi);
    trig_of(angle_q13[REG_PITCH], sth, cth);
    trig_of(angle_q13[REG_YAW], spsi, cpsi);
    cps = q30_mul(cpsi, sth);
    sps = q30_mul(spsi, sth);
    dcm[0] = q15_sat(q30_mul(cpsi, cth));
    dcm[1] = q15_sat(q30_mul(spsi, cth));
    dcm[2] = q15_sat(-sth);
    dcm[3] = q15_sat(q30_mul(cps, sphi) - q30_mul(spsi, cphi));
    dcm[4] = q15_sat(q30_mul(sps, sphi) + q30_mul(cpsi, cphi));
    dcm[5] = q15_sat(q30_mul(cth, sphi));
    dcm[6] = q15_sat(q30_mul(cps, cphi) + q30_mul(spsi, sphi));
    dcm[7] = q15_sat(q30_mul(sps, cphi) - q30_mul(cpsi, sphi));
    dcm[8] = q15_sat(q30_mul(cth, cphi));
  endtask

  function automatic rot_vec_t rotate_vec(logic [71:0] d, logic transp);
    longint v [3];
    longint acc [3];
    rot_vec_t r;
    v[0] = longint'($signed(d[23:0]));
    v[1] = longint'($signed(d[47:24]));
    v[2] = longint'($signed(d[71:48]));
    for (int row = 0; row < 3; row++) begin
      acc[row] = 0;
      for (int col = 0; col < 3; col++)
        acc[row] += (transp ? dcm[col*3+row] : dcm[row*3+col]) * v[col];
      acc[row] = (acc[row] + 16384) >>> 15;
    end
    r.rot_x = acc[0][25:0];
    r.rot_y = acc[1][25:0];
    r.rot_z = acc[2][25:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [25:0] got,
                                 input logic [25:0] want);
    $display("%0t: %s got %0d want %0d", $realtime, what, $signed(got), $signed(want));
    fail_count++;
  endtask

  // Track configuration, predict accepted items and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    rot_vec_t got, want;
    if (!rst_ni) begin
      fail_count <= 0;
      result_count <= 0;
      rot_expected_q.delete();
      for (int i = 0; i < 3; i++) angle_q13[i] = 0;
      for (int i = 0; i < 9; i++) dcm[i] = (i % 4 == 0) ? 32767 : 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count <= result_count + 1;
        got = m_axis_tdata[77:0];
        if (m_axis_tdata[79:78] != 2'b00)
          report_mismatch("pad bits", 26'(m_axis_tdata[79:78]), 26'd0);
        if (rot_expected_q.size() == 0) begin
          $display("%0t: result item with none expected", $realtime);
          fail_count++;
        end else begin
          want = rot_expected_q.pop_front();
          if (got.rot_x != want.rot_x) report_mismatch("rot_x", got.rot_x, want.rot_x);
          if (got.rot_y != want.rot_y) report_mismatch("rot_y", got.rot_y, want.rot_y);
          if (got.rot_z != want.rot_z) report_mismatch("rot_z", got.rot_z, want.rot_z);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        rot_expected_q.push_back(rotate_vec(s_axis_tdata, s_axis_tuser[0]));
      if (cfg_we_i && cfg_idx_i <= REG_YAW) begin
        angle_q13[cfg_idx_i] = longint'($signed(cfg_data_i));
        rebuild_dcm();
      end
    end
  end

endmodule

FILE: sim/euler_rotation_vector_transform_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for euler_rotation_vector_transform_unit: drives angle settings
// and vector items, and takes the verdict from erv_rotation_checker.
module euler_rotation_vector_transform_unit_test;
  import erv_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int REBUILD_WAIT = 3 * 25 + 16 + 20;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // vec_x [23:0], vec_y [47:24], vec_z [71:48]
  logic [0:0]  s_axis_tuser = '0;   // action [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;        // rot_x [25:0], rot_y [51:26], rot_z [77:52], zero
  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  int items_sent = 0;
  int hold_off = 0;
  int burst_left = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  euler_rotation_vector_transform_unit u_dut (.*);

  erv_rotation_checker u_check (.*);

  // Receiver stalls on its own pattern, with a single long hold-off in the random phases.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      case ((result_count / 128) % 3)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 2000) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until accepted; gaps come between bursts.
  task automatic send_vec(input logic act, input logic [23:0] x, input logic [23:0] y,
                          input logic [23:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic write_angle(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    repeat (REBUILD_WAIT) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] ang;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes and both actions at the reset matrix.
    send_vec(0, 24'h7FFFFF, 24'h800000, 24'h000000);
    send_vec(1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    send_vec(0, 24'hFFFFFF, 24'h000001, 24'h7FFFFF);
    send_vec(1, 24'h000000, 24'h000000, 24'h800000);
    drain();
    // Angles past a quarter turn, full-scale pattern and the extremes.
    write_angle(REG_ROLL, 16'sd25736);
    write_angle(REG_PITCH, -16'sd25736);
    write_angle(REG_YAW, 16'sd12869);
    for (int i = 0; i < 4; i++)
      send_vec(i[0], 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    drain();
    write_angle(REG_ROLL, 16'h7FFF);
    write_angle(REG_PITCH, 16'h8000);
    write_angle(REG_YAW, -16'sd12869);
    send_vec(0, 24'h800000, 24'h800000, 24'h800000);
    send_vec(1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    drain();
    write_angle(REG_PITCH, 16'sd12868);
    send_vec(0, 24'h123456, 24'hABCDEF, 24'h7FFFFF);
    send_vec(1, 24'h123456, 24'hABCDEF, 24'h7FFFFF);
    drain();
    // Unused index leaves the matrix as it was.
    cfg_we_i <= 1;
    cfg_idx_i <= 2'd3;
    cfg_data_i <= 16'h1234;
    @(posedge clk_i);
    cfg_we_i <= 0;
    repeat (REBUILD_WAIT) @(posedge clk_i);
    send_vec(0, 24'h000100, 24'h000200, 24'h000300);
    drain();

    // Random phases: new angles, then a stream of vectors.
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 3; r++) begin
        ang = (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
        write_angle(cfg_reg_e'(r), ang);
      end
      if (ph == 4) hold_off = 300;
      for (int k = 0; k < 100; k++)
        send_vec($urandom_range(0, 1), rand_comp(), rand_comp(), rand_comp());
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d vectors, checked %0d rotated results over 14 angle settings.",
             items_sent, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
src/erv_pkg.sv
src/erv_dcm.sv
src/erv_mvm.sv
src/euler_rotation_vector_transform_unit.sv
sim/erv_rotation_checker.sv
sim/euler_rotation_vector_transform_unit_test.sv
